### rtl/cau_pkg.sv
// cau_pkg: shared types, constants and helper functions of the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

  localparam int unsigned DataWidth  = 16;
  localparam int unsigned FracBits   = 11;
  localparam int unsigned CordSteps  = 16;
  localparam int unsigned DivSteps   = 17;
  localparam int unsigned NumCells   = DivSteps;
  localparam int unsigned AngShift   = 19;
  localparam int unsigned XW         = 36;
  localparam int unsigned ZW         = 34;
  localparam int unsigned RemW       = 43;
  localparam int unsigned NumStages  = NumCells + 3;

  localparam logic signed [ZW-1:0] HalfPi = 34'sd1686629713;
  localparam logic [DataWidth-1:0] MaxPos = 16'h7fff;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MAG   = 3'd4,
    OP_PHASE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [DataWidth-1:0] val;
    logic                 sat;
  } sat_t;

  typedef struct packed {
    logic [2:0]              op;
    logic [DataWidth-1:0]    as_re;
    logic [DataWidth-1:0]    as_im;
    logic                    as_sat;
    logic signed [31:0]      p0;
    logic signed [31:0]      p1;
    logic signed [31:0]      p2;
    logic signed [31:0]      p3;
    logic signed [31:0]      p4;
    logic signed [31:0]      p5;
    logic signed [XW-1:0]    cx;
    logic signed [XW-1:0]    cy;
    logic signed [ZW-1:0]    cz;
    logic                    pzero;
  } stage_a_t;

  typedef struct packed {
    logic [2:0]              op;
    logic [DataWidth-1:0]    fr;
    logic [DataWidth-1:0]    fi;
    logic                    fsat;
    logic                    dz;
    logic                    ovf_re;
    logic                    ovf_im;
    logic                    neg_re;
    logic                    neg_im;
    logic [31:0]             den;
    logic [RemW-1:0]         rem_re;
    logic [RemW-1:0]         rem_im;
    logic [DivSteps-1:0]     q_re;
    logic [DivSteps-1:0]     q_im;
    logic [31:0]             sres;
    logic [31:0]             srem;
    logic signed [XW-1:0]    cx;
    logic signed [XW-1:0]    cy;
    logic signed [ZW-1:0]    cz;
    logic                    pzero;
  } cell_t;

  // saturate a sign and magnitude pair to the signed word range
  function automatic sat_t sat16(input logic neg, input logic [33:0] m);
    sat_t r;
    if (neg) begin
      if (m > 34'd32768) begin
        r.val = 16'h8000;
        r.sat = 1'b1;
      end else begin
        r.val = 16'((~m) + 34'd1);
        r.sat = 1'b0;
      end
    end else begin
      if (m > 34'd32767) begin
        r.val = MaxPos;
        r.sat = 1'b1;
      end else begin
        r.val = m[15:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic sat_t clip17(input logic signed [16:0] v);
    sat_t r;
    if (v > 17'sd32767) begin
      r.val = MaxPos;
      r.sat = 1'b1;
    end else if (v < -17'sd32768) begin
      r.val = 16'h8000;
      r.sat = 1'b1;
    end else begin
      r.val = v[15:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // atan(2^-i) in q2.30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0:    r = 34'sh03243F6A8;
      4'd1:    r = 34'sh01DAC6705;
      4'd2:    r = 34'sh00FADBAFC;
      4'd3:    r = 34'sh007F56EA6;
      4'd4:    r = 34'sh003FEAB76;
      4'd5:    r = 34'sh001FFD55B;
      4'd6:    r = 34'sh000FFFAAA;
      4'd7:    r = 34'sh0007FFF55;
      4'd8:    r = 34'sh0003FFFEA;
      4'd9:    r = 34'sh0001FFFFD;
      4'd10:   r = 34'sh0000FFFFF;
      4'd11:   r = 34'sh00007FFFF;
      4'd12:   r = 34'sh00003FFFF;
      4'd13:   r = 34'sh00001FFFF;
      4'd14:   r = 34'sh00000FFFF;
      4'd15:   r = 34'sh000007FFF;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/cau_if.sv
// cau_req_if and cau_res_if: valid/ready channels of the complex arithmetic unit
// no dependencies
`default_nettype none

interface cau_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] a_re;
  logic signed [15:0] a_im;
  logic signed [15:0] b_re;
  logic signed [15:0] b_im;

  modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] res_re;
  logic signed [15:0] res_im;
  logic [1:0]         status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

`default_nettype wire

### rtl/complex_arith_unit.sv
// complex_arith_unit: top level of the pipelined fixed-point complex alu
// depends on cau_pkg, cau_if, cau_front, cau_cell, cau_back
//
// usage
//   req_i carries one word per operation: opcode and two q4.11 complex operands
//   res_o carries one word per operation: real part, imaginary part, status
//   add, sub, mul, div, magnitude and phase all run through the same pipeline:
//   a product stage, a combine stage, a row of 17 cells (one restoring divide
//   step each, the first 16 also one square root step and one cordic rotation)
//   and an output register that drives res_o
//   throughput is one word per cycle while res_o.ready stays high, results leave in order
//   each stage moves on when it is empty or its successor moves, so bubbles
//   collapse and req_i.ready stays high until every stage holds a word
//   while res_o.ready is low the output word holds and the row fills behind it
//   reset clears all valid flags; nothing else needs clearing
`default_nettype none

module complex_arith_unit (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cau_req_if.sink      req_i,
  cau_res_if.source    res_o
);

  localparam int unsigned NS = cau_pkg::NumStages;
  localparam int unsigned NC = cau_pkg::NumCells;

  logic [NS-1:0]  v;
  logic [NS-1:0]  en;
  cau_pkg::cell_t c [NC+1];
  logic [15:0]    rre, rim;
  logic [1:0]     rst_s;

  always_comb begin
    en[NS-1] = !v[NS-1] || res_o.ready;
    for (int j = NS - 2; j >= 0; j--) begin
      en[j] = !v[j] || en[j+1];
    end
  end

  assign req_i.ready = en[0];

  cau_front u_front (
    .clk_i,
    .rst_ni,
    .en_a_i     (en[0]),
    .en_b_i     (en[1]),
    .valid_i    (req_i.valid),
    .req_type_i (req_i.req_type),
    .a_re_i     (req_i.a_re),
    .a_im_i     (req_i.a_im),
    .b_re_i     (req_i.b_re),
    .b_im_i     (req_i.b_im),
    .valid_a_o  (v[0]),
    .valid_b_o  (v[1]),
    .cell_o     (c[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    cau_cell #(.STEP(i)) u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (en[i+2]),
      .valid_i (v[i+1]),
      .d_i     (c[i]),
      .valid_o (v[i+2]),
      .q_o     (c[i+1])
    );
  end

  cau_back u_back (
    .clk_i,
    .rst_ni,
    .en_i     (en[NS-1]),
    .valid_i  (v[NS-2]),
    .c_i      (c[NC]),
    .valid_o  (v[NS-1]),
    .res_re_o (rre),
    .res_im_o (rim),
    .status_o (rst_s)
  );

  assign res_o.valid  = v[NS-1];
  assign res_o.res_re = rre;
  assign res_o.res_im = rim;
  assign res_o.status = rst_s;

`ifndef SYNTHESIS
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input stalled without an output stall");

  a_divz_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == cau_pkg::ST_DIVZ) |->
      (res_o.res_re == cau_pkg::MaxPos && res_o.res_im == cau_pkg::MaxPos))
    else $error("divide by zero word without saturated parts");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.status != 2'd3))
    else $error("undefined status code");
`endif

endmodule

`default_nettype wire

### rtl/cau_front.sv
// cau_front: product stage and combine stage feeding the cell row
// depends on cau_pkg
`default_nettype none

module cau_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_a_i,
  input  wire logic               en_b_i,
  input  wire logic               valid_i,
  input  wire logic [2:0]         req_type_i,
  input  wire logic signed [15:0] a_re_i,
  input  wire logic signed [15:0] a_im_i,
  input  wire logic signed [15:0] b_re_i,
  input  wire logic signed [15:0] b_im_i,
  output logic                    valid_a_o,
  output logic                    valid_b_o,
  output cau_pkg::cell_t          cell_o
);

  cau_pkg::stage_a_t a_d, a_q;
  cau_pkg::cell_t    b_d, b_q;
  logic              va_q, vb_q;

  logic signed [16:0] s_re, s_im, x0, y0, xe, ye;
  logic signed [15:0] m4, m5;
  logic signed [cau_pkg::XW-1:0] xw, yw;
  cau_pkg::sat_t c_re, c_im;
  logic sub;

  always_comb begin
    sub  = (req_type_i == cau_pkg::OP_SUB);
    s_re = sub ? (17'(a_re_i) - 17'(b_re_i)) : (17'(a_re_i) + 17'(b_re_i));
    s_im = sub ? (17'(a_im_i) - 17'(b_im_i)) : (17'(a_im_i) + 17'(b_im_i));
    c_re = cau_pkg::clip17(s_re);
    c_im = cau_pkg::clip17(s_im);
    a_d.op     = req_type_i;
    a_d.as_re  = c_re.val;
    a_d.as_im  = c_im.val;
    a_d.as_sat = c_re.sat | c_im.sat;
    m4 = (req_type_i == cau_pkg::OP_MAG) ? a_re_i : b_re_i;
    m5 = (req_type_i == cau_pkg::OP_MAG) ? a_im_i : b_im_i;
    a_d.p0 = a_re_i * b_re_i;
    a_d.p1 = a_im_i * b_im_i;
    a_d.p2 = a_re_i * b_im_i;
    a_d.p3 = b_re_i * a_im_i;
    a_d.p4 = m4 * m4;
    a_d.p5 = m5 * m5;
    xe = 17'(a_re_i);
    ye = 17'(a_im_i);
    // quadrant fold onto the right half plane
    if (a_re_i < 0) begin
      if (a_im_i >= 0) begin
        x0 = ye;
        y0 = -xe;
        a_d.cz = cau_pkg::HalfPi;
      end else begin
        x0 = -ye;
        y0 = xe;
        a_d.cz = -cau_pkg::HalfPi;
      end
    end else begin
      x0 = xe;
      y0 = ye;
      a_d.cz = '0;
    end
    xw = cau_pkg::XW'(x0);
    yw = cau_pkg::XW'(y0);
    a_d.cx = xw <<< 16;
    a_d.cy = yw <<< 16;
    a_d.pzero = (a_re_i == 0) && (a_im_i == 0);
  end

  logic signed [32:0] mre, mim, nre, nim;
  logic [32:0] amre, amim, anre, anim;
  cau_pkg::sat_t r_re, r_im;

  always_comb begin
    mre  = 33'(a_q.p0) - 33'(a_q.p1);
    mim  = 33'(a_q.p2) + 33'(a_q.p3);
    amre = cau_pkg::abs33(mre);
    amim = cau_pkg::abs33(mim);
    r_re = cau_pkg::sat16(mre[32], {12'b0, amre[32:11]} + 34'(amre[10]));
    r_im = cau_pkg::sat16(mim[32], {12'b0, amim[32:11]} + 34'(amim[10]));
    nre  = 33'(a_q.p0) + 33'(a_q.p1);
    nim  = 33'(a_q.p3) - 33'(a_q.p2);
    anre = cau_pkg::abs33(nre);
    anim = cau_pkg::abs33(nim);
    b_d.op = a_q.op;
    case (a_q.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        b_d.fr   = a_q.as_re;
        b_d.fi   = a_q.as_im;
        b_d.fsat = a_q.as_sat;
      end
      cau_pkg::OP_MUL: begin
        b_d.fr   = r_re.val;
        b_d.fi   = r_im.val;
        b_d.fsat = r_re.sat | r_im.sat;
      end
      default: begin
        b_d.fr   = '0;
        b_d.fi   = '0;
        b_d.fsat = 1'b0;
      end
    endcase
    b_d.den    = 32'(a_q.p4) + 32'(a_q.p5);
    b_d.dz     = (b_d.den == 32'd0);
    b_d.neg_re = nre[32];
    b_d.neg_im = nim[32];
    b_d.ovf_re = {6'b0, anre[31:0]} >= {b_d.den, 6'b0};
    b_d.ovf_im = {6'b0, anim[31:0]} >= {b_d.den, 6'b0};
    b_d.rem_re = {anre[31:0], 11'b0};
    b_d.rem_im = {anim[31:0], 11'b0};
    b_d.q_re   = '0;
    b_d.q_im   = '0;
    b_d.sres   = '0;
    b_d.srem   = b_d.den;
    b_d.cx     = a_q.cx;
    b_d.cy     = a_q.cy;
    b_d.cz     = a_q.cz;
    b_d.pzero  = a_q.pzero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a_i) va_q <= valid_i;
      if (en_b_i) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) a_q <= a_d;
    if (en_b_i) b_q <= b_d;
  end

  assign valid_a_o = va_q;
  assign valid_b_o = vb_q;
  assign cell_o    = b_q;

endmodule

`default_nettype wire

### rtl/cau_cell.sv
// cau_cell: one step of divider, square root and cordic (the last two only while STEP < CordSteps), registered
// depends on cau_pkg
`default_nettype none

module cau_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     valid_i,
  input  cau_pkg::cell_t d_i,
  output logic          valid_o,
  output cau_pkg::cell_t q_o
);

  localparam int unsigned K  = cau_pkg::DivSteps - 1 - STEP;
  localparam int unsigned SB = (STEP < cau_pkg::CordSteps) ? 30 - 2 * STEP : 0;

  cau_pkg::cell_t n;
  cau_pkg::cell_t q_q;
  logic           v_q;
  logic [48:0]    dk;
  logic [31:0]    sbit, strial;
  logic signed [cau_pkg::XW-1:0] dx, dy;
  logic signed [cau_pkg::ZW-1:0] at;

  always_comb begin
    n  = d_i;
    dk = 49'(d_i.den) << K;
    if (49'(d_i.rem_re) >= dk) begin
      n.rem_re  = d_i.rem_re - dk[cau_pkg::RemW-1:0];
      n.q_re[K] = 1'b1;
    end
    if (49'(d_i.rem_im) >= dk) begin
      n.rem_im  = d_i.rem_im - dk[cau_pkg::RemW-1:0];
      n.q_im[K] = 1'b1;
    end
    sbit   = 32'd1 << SB;
    strial = d_i.sres + sbit;
    dx     = d_i.cy >>> STEP;
    dy     = d_i.cx >>> STEP;
    at     = cau_pkg::atan_q30(4'(STEP));
    if (STEP < cau_pkg::CordSteps) begin
      if (d_i.srem >= strial) begin
        n.srem = d_i.srem - strial;
        n.sres = (d_i.sres >> 1) + sbit;
      end else begin
        n.sres = d_i.sres >> 1;
      end
      if (d_i.cy >= 0) begin
        n.cx = d_i.cx + dx;
        n.cy = d_i.cy - dy;
        n.cz = d_i.cz + at;
      end else begin
        n.cx = d_i.cx - dx;
        n.cy = d_i.cy + dy;
        n.cz = d_i.cz - at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= n;
  end

  assign valid_o = v_q;
  assign q_o     = q_q;

endmodule

`default_nettype wire

### rtl/cau_back.sv
// cau_back: final rounding, saturation and output register
// depends on cau_pkg
`default_nettype none

module cau_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     valid_i,
  input  cau_pkg::cell_t c_i,
  output logic          valid_o,
  output logic [15:0]   res_re_o,
  output logic [15:0]   res_im_o,
  output logic [1:0]    status_o
);

  logic        v_q;
  logic [15:0] re_q, im_q, re_d, im_d;
  logic [1:0]  st_q, st_d;
  logic [17:0] qr, qi, sr;
  logic [cau_pkg::ZW-1:0] zm;
  cau_pkg::sat_t dre, dim, sq, ph;
  logic        sat;

  always_comb begin
    qr  = 18'(c_i.q_re) + 18'({c_i.rem_re, 1'b0} >= 44'(c_i.den));
    qi  = 18'(c_i.q_im) + 18'({c_i.rem_im, 1'b0} >= 44'(c_i.den));
    dre = cau_pkg::sat16(c_i.neg_re, c_i.ovf_re ? 34'h3ffff : 34'(qr));
    dim = cau_pkg::sat16(c_i.neg_im, c_i.ovf_im ? 34'h3ffff : 34'(qi));
    sr  = 18'(c_i.sres) + 18'(c_i.srem > c_i.sres);
    sq  = cau_pkg::sat16(1'b0, 34'(sr));
    zm  = c_i.cz[cau_pkg::ZW-1] ? cau_pkg::ZW'(-c_i.cz) : cau_pkg::ZW'(c_i.cz);
    ph  = cau_pkg::sat16(c_i.cz[cau_pkg::ZW-1],
                         34'(zm >> cau_pkg::AngShift) + 34'(zm[cau_pkg::AngShift-1]));
    re_d = '0;
    im_d = '0;
    st_d = cau_pkg::ST_OK;
    sat  = 1'b0;
    case (c_i.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        re_d = c_i.fr;
        im_d = c_i.fi;
        sat  = c_i.fsat;
      end
      cau_pkg::OP_DIV: begin
        if (c_i.dz) begin
          re_d = cau_pkg::MaxPos;
          im_d = cau_pkg::MaxPos;
          st_d = cau_pkg::ST_DIVZ;
        end else begin
          re_d = dre.val;
          im_d = dim.val;
          sat  = dre.sat | dim.sat;
        end
      end
      cau_pkg::OP_MAG: begin
        re_d = sq.val;
        sat  = sq.sat;
      end
      cau_pkg::OP_PHASE: begin
        if (!c_i.pzero) begin
          re_d = ph.val;
          sat  = ph.sat;
        end
      end
      default: begin
        re_d = '0;
      end
    endcase
    if (sat && st_d == cau_pkg::ST_OK) st_d = cau_pkg::ST_SAT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q <= re_d;
      im_q <= im_d;
      st_q <= st_d;
    end
  end

  assign valid_o  = v_q;
  assign res_re_o = re_q;
  assign res_im_o = im_q;
  assign status_o = st_q;

endmodule

`default_nettype wire

### dv/complex_arith_unit_test.sv
// complex_arith_unit_test: self-checking testbench of the complex arithmetic unit
// drives cau_req_if words, predicts each result word (or takes it from the directed row) and compares it on cau_res_if
// depends on cau_pkg, cau_if and complex_arith_unit
`timescale 1ns / 1ps

module complex_arith_unit_test;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ar;
    logic [15:0] ai;
    logic [15:0] br;
    logic [15:0] bi;
  } req_word_t;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic [1:0]  st;
  } res_word_t;

  typedef struct {
    req_word_t w;
    bit        known;
    res_word_t r;
  } vec_t;

  localparam longint ATAN_TAB [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors = 0;
  res_word_t expected_q[$];

  cau_req_if req_if ();
  cau_res_if res_if ();

  complex_arith_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  always #1 clk_i = ~clk_i;

  // rounded shift and saturation of a sign and magnitude pair
  function automatic logic [15:0] round_sat(input bit neg, input longint unsigned mag,
                                            input int sh, inout bit sat);
    longint unsigned m;
    m = mag;
    if (sh > 0) m = (mag >> sh) + ((mag >> (sh - 1)) & 1);
    if (neg) begin
      if (m > 32768) begin m = 32768; sat = 1; end
      return 16'(-longint'(m));
    end
    if (m > 32767) begin m = 32767; sat = 1; end
    return 16'(m);
  endfunction

  function automatic longint unsigned mag_of(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned quot_round(input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned cap, q, r;
    bit big;
    cap = 64'd1 << 17;
    q = num / den;
    r = num % den;
    big = q > cap;
    for (int k = 0; k < cau_pkg::FracBits && !big; k++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin r -= den; q++; end
      if (q > cap) big = 1;
    end
    if (big) return cap;
    if (r * 2 >= den) q++;
    return q;
  endfunction

  function automatic longint unsigned sqrt_round(input longint unsigned n);
    longint unsigned res, b, rem;
    res = 0;
    b = 64'd1 << 62;
    rem = n;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else res = res >> 1;
      b = b >> 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic longint cordic_angle(input longint x0, input longint y0);
    longint x, y, z, t, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin x = y; y = -t; z = cau_pkg::HalfPi; end
      else begin x = -y; y = t; z = -longint'(cau_pkg::HalfPi); end
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < cau_pkg::CordSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin x += dx; y -= dy; z += ATAN_TAB[i]; end
      else begin x -= dx; y += dy; z -= ATAN_TAB[i]; end
    end
    return z;
  endfunction

  function automatic res_word_t complex_result(input req_word_t w);
    longint ar, ai, br, bi, p, q, z;
    longint unsigned den;
    bit sat;
    res_word_t r;
    ar = longint'($signed(w.ar));
    ai = longint'($signed(w.ai));
    br = longint'($signed(w.br));
    bi = longint'($signed(w.bi));
    sat = 0;
    r = '0;
    case (w.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        p = (w.op == cau_pkg::OP_SUB) ? ar - br : ar + br;
        q = (w.op == cau_pkg::OP_SUB) ? ai - bi : ai + bi;
        r.re = round_sat(p < 0, mag_of(p), 0, sat);
        r.im = round_sat(q < 0, mag_of(q), 0, sat);
      end
      cau_pkg::OP_MUL: begin
        p = ar * br - ai * bi;
        q = ar * bi + br * ai;
        r.re = round_sat(p < 0, mag_of(p), cau_pkg::FracBits, sat);
        r.im = round_sat(q < 0, mag_of(q), cau_pkg::FracBits, sat);
      end
      cau_pkg::OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.re = cau_pkg::MaxPos;
          r.im = cau_pkg::MaxPos;
          r.st = cau_pkg::ST_DIVZ;
          return r;
        end
        p = ar * br + ai * bi;
        q = br * ai - ar * bi;
        r.re = round_sat(p < 0, quot_round(mag_of(p), den), 0, sat);
        r.im = round_sat(q < 0, quot_round(mag_of(q), den), 0, sat);
      end
      cau_pkg::OP_MAG: r.re = round_sat(0, sqrt_round(ar * ar + ai * ai), 0, sat);
      cau_pkg::OP_PHASE: begin
        if (ar != 0 || ai != 0) begin
          z = cordic_angle(ar, ai);
          r.re = round_sat(z < 0, mag_of(z), cau_pkg::AngShift, sat);
        end
      end
      default: ;
    endcase
    r.st = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    return r;
  endfunction

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'h8000 + 16'($urandom_range(0, 3));
      1: return 16'h7fff - 16'($urandom_range(0, 3));
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      3: return 16'($signed($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_word_t rand_req();
    req_word_t w;
    w.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    w.ar = rand_operand();
    w.ai = rand_operand();
    w.br = rand_operand();
    w.bi = rand_operand();
    if (w.op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
      w.br = '0;
      w.bi = '0;
    end
    if (w.op == cau_pkg::OP_PHASE && $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) w.ai = '0;
      else w.ar = '0;
    end
    return w;
  endfunction

  function automatic vec_t row(input logic [2:0] op, input logic [15:0] ar, ai, br, bi,
                               input bit known = 0, input res_word_t r = '0);
    vec_t v;
    v.w = '{op, ar, ai, br, bi};
    v.known = known;
    v.r = r;
    return v;
  endfunction

  vec_t directed[$];

  task automatic send_word(input req_word_t w, input bit known, input res_word_t r);
    req_if.valid    <= 1'b1;
    req_if.req_type <= w.op;
    req_if.a_re     <= w.ar;
    req_if.a_im     <= w.ai;
    req_if.b_re     <= w.br;
    req_if.b_im     <= w.bi;
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(known ? r : complex_result(w));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = '0;
    req_if.a_re     = '0;
    req_if.a_im     = '0;
    req_if.b_re     = '0;
    req_if.b_im     = '0;
    directed.push_back(row(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 1,
                           '{16'h7fff, 16'h8000, cau_pkg::ST_SAT}));
    directed.push_back(row(cau_pkg::OP_ADD, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1,
                           '{16'h0004, 16'h0006, cau_pkg::ST_OK}));
    directed.push_back(row(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1,
                           '{16'h8000, 16'h7fff, cau_pkg::ST_SAT}));
    directed.push_back(row(cau_pkg::OP_SUB, 16'h0005, 16'h0000, 16'h0002, 16'h0001));
    directed.push_back(row(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    directed.push_back(row(cau_pkg::OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000));
    directed.push_back(row(cau_pkg::OP_MUL, 16'h0800, 16'h0000, 16'h0400, 16'hfc00));
    directed.push_back(row(cau_pkg::OP_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000, 1,
                           '{cau_pkg::MaxPos, cau_pkg::MaxPos, cau_pkg::ST_DIVZ}));
    directed.push_back(row(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000));
    directed.push_back(row(cau_pkg::OP_DIV, 16'h0800, 16'h0800, 16'h0800, 16'hf800));
    directed.push_back(row(cau_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000));
    directed.push_back(row(cau_pkg::OP_MAG, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1,
                           '{cau_pkg::MaxPos, 16'h0000, cau_pkg::ST_SAT}));
    directed.push_back(row(cau_pkg::OP_MAG, 16'h0003, 16'hfffc, 16'hffff, 16'hffff, 1,
                           '{16'h0005, 16'h0000, cau_pkg::ST_OK}));
    directed.push_back(row(cau_pkg::OP_MAG, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 1,
                           '{16'h0000, 16'h0000, cau_pkg::ST_OK}));
    directed.push_back(row(cau_pkg::OP_PHASE, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 1,
                           '{16'h0000, 16'h0000, cau_pkg::ST_OK}));
    directed.push_back(row(cau_pkg::OP_PHASE, 16'hf800, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(row(cau_pkg::OP_PHASE, 16'h8000, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(row(cau_pkg::OP_PHASE, 16'h0000, 16'h8000, 16'h0000, 16'h0000));
    directed.push_back(row(cau_pkg::OP_PHASE, 16'h0000, 16'h7fff, 16'h0000, 16'h0000));
    directed.push_back(row(cau_pkg::OP_PHASE, 16'h8000, 16'hffff, 16'h0000, 16'h0000));
    directed.push_back(row(cau_pkg::OP_PHASE, 16'h0800, 16'h0800, 16'h0000, 16'h0000));
    directed.push_back(row(3'd6, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1, '0));
    directed.push_back(row(3'd7, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, '0));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_word(directed[i].w, directed[i].known, directed[i].r);
    for (int i = 0; i < 1850; i++) begin
      send_word(rand_req(), 0, '0);
      idle_gap();
    end
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("complex_arith_unit_test: clean");
    else $display("complex_arith_unit_test: errors");
    $finish;
  end

  // receiver stall pattern: long open stretches, then bursts of random stalls
  int stall_phase = 0;
  initial res_if.ready = 1'b0;
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 100) res_if.ready <= 1'b1;
    else if (stall_phase < 200) res_if.ready <= $urandom_range(0, 2) != 0;
    else res_if.ready <= $urandom_range(0, 3) == 0;
  end

  always @(posedge clk_i) begin
    res_word_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.res_re, res_if.res_im, res_if.status};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word re=%h im=%h st=%0d", $time, got.re, got.im, got.st);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.re !== want.re) begin
          $display("%0t: res_re expected %h actual %h", $time, want.re, got.re);
          errors++;
        end
        if (got.im !== want.im) begin
          $display("%0t: res_im expected %h actual %h", $time, want.im, got.im);
          errors++;
        end
        if (got.st !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          errors++;
        end
      end
    end
  end

  initial begin
    #200000;
    $display("complex_arith_unit_test: errors");
    $finish;
  end

endmodule
